// ----- hw/rtl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants of the token bucket shaper.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);
    localparam int PADDR_W       = 3;
    localparam logic [15:0] INTERVAL_RESET = 16'd1;
    localparam logic [7:0]  DEPTH_RESET    = 8'd10;

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_ARRIVAL = 1'b1
    } kind_t;

    typedef enum logic {
        REG_TOKEN_INTERVAL = 1'b0,
        REG_BUCKET_DEPTH   = 1'b1
    } reg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] packet_id;
        logic [7:0]  packet_size;
    } cmd_t;

    typedef struct packed {
        logic [15:0] token_interval;
        logic [7:0]  bucket_depth;
    } cfg_t;

    typedef struct packed {
        logic        token_added;
        logic        token_dropped;
        logic        packet_released;
        logic [15:0] released_id;
        logic [7:0]  released_size;
        logic        packet_refused;
        logic [7:0]  tokens_now;
        logic [4:0]  queue_count;
    } result_t;

endpackage

// ----- hw/rtl/tbs_front.sv -----
// ----------------------------------------------------------------------------
// tbs_front
// Accepts input items, classifies them by kind and queues them for the back.
// ----------------------------------------------------------------------------
module tbs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  logic          func,
    input  logic [15:0]   packet_id,
    input  logic [7:0]    packet_size,
    output logic          cmd_valid,
    output tbs_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import tbs_pkg::*;

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  push;
    cmd_t                  classified;

    assign item_stall = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        classified.kind        = (func == 1'b1) ? KIND_ARRIVAL : KIND_TICK;
        classified.packet_id   = packet_id;
        classified.packet_size = packet_size;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ----- hw/rtl/tbs_back.sv -----
// ----------------------------------------------------------------------------
// tbs_back
// Executes ticks and arrivals against the bucket and packet queue, one a cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module tbs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tbs_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  tbs_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output tbs_pkg::result_t result
);
    import tbs_pkg::*;

    logic [15:0]       tick_count_reg, tick_count_next;
    logic [7:0]        token_count_reg, token_count_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              result_valid_reg;
    result_t           result_reg, result_next;
    logic [15:0]       queue_ids [QUEUE_DEPTH];
    logic [7:0]        queue_sizes [QUEUE_DEPTH];

    logic              fire;
    logic              enqueue;
    logic [15:0]       limit;
    logic [15:0]       tick_inc;
    logic              deposit;
    logic [8:0]        token_inc;
    logic [7:0]        head_size;
    logic              queue_empty;
    logic              queue_full;

    assign fire         = cmd_valid && (!result_valid_reg || !result_stall);
    assign cmd_pop      = fire;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign limit       = (cfg.token_interval == '0) ? 16'd1 : cfg.token_interval;
    assign tick_inc    = tick_count_reg + 16'd1;
    assign deposit     = (tick_inc >= limit) || (tick_inc == '0);
    assign token_inc   = {1'b0, token_count_reg} + 9'd1;
    assign head_size   = queue_sizes[head_reg];
    assign queue_empty = (fill_reg == '0);
    assign queue_full  = (fill_reg >= FILL_W'(QUEUE_DEPTH));

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        token_count_next = token_count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        enqueue          = 1'b0;
        result_next      = '0;
        case (cmd.kind)
            KIND_TICK:
            begin
                tick_count_next = tick_inc;
                if (deposit)
                begin
                    tick_count_next = '0;
                    if (token_inc > {1'b0, cfg.bucket_depth})
                    begin
                        result_next.token_dropped = 1'b1;
                    end
                    else
                    begin
                        result_next.token_added = 1'b1;
                        token_count_next        = token_inc[7:0];
                        if (!queue_empty && (head_size <= token_inc[7:0]))
                        begin
                            result_next.packet_released = 1'b1;
                            result_next.released_id     = queue_ids[head_reg];
                            result_next.released_size   = head_size;
                            token_count_next            = token_inc[7:0] - head_size;
                            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                              : head_reg + 1'b1;
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                end
            end
            KIND_ARRIVAL:
            begin
                if ((cmd.packet_size > cfg.bucket_depth) || queue_full)
                begin
                    result_next.packet_refused = 1'b1;
                end
                else if (queue_empty && (cmd.packet_size <= token_count_reg))
                begin
                    result_next.packet_released = 1'b1;
                    result_next.released_id     = cmd.packet_id;
                    result_next.released_size   = cmd.packet_size;
                    token_count_next            = token_count_reg - cmd.packet_size;
                end
                else
                begin
                    enqueue   = 1'b1;
                    tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
        result_next.tokens_now  = token_count_next;
        result_next.queue_count = 5'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            token_count_reg  <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                tick_count_reg  <= tick_count_next;
                token_count_reg <= token_count_next;
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                fill_reg        <= fill_next;
            end
            if (fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
        if (fire && enqueue)
        begin
            queue_ids[tail_reg]   <= cmd.packet_id;
            queue_sizes[tail_reg] <= cmd.packet_size;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("packet queue fill above depth");

    a_token_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.token_added && result_reg.token_dropped))
        else $error("token added and dropped together");

    a_refuse_release: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.packet_refused |-> !result_reg.packet_released)
        else $error("arrival refused and released together");

    a_release_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.packet_released
            |-> (result_reg.released_id == '0) && (result_reg.released_size == '0))
        else $error("release fields set without a release");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |=> result_valid_reg && $stable(result_reg))
        else $error("result changed while stalled");
`endif

endmodule

// ----- hw/rtl/token_bucket_shaper_unit.sv -----
// ----------------------------------------------------------------------------
// token_bucket_shaper_unit
// Token bucket shaper: ticks deposit tokens, arrivals queue or release packets.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       func, packet_id, packet_size
//  result    out        result_valid / result_stall   token_added .. queue_count
//  config    in         APB psel/penable/pready       paddr, pwdata, prdata
//
//  One item per cycle sustained while the result is not stalled; the back executes one queued command a cycle.
//  An item passes the command queue, then the back's result register, before
//  result_valid rises for it.
//  Reset clears the bucket, counters and packet queue; interval 1, depth 10.
//  item_stall rises only when the two-entry command queue is full.
//  A stalled result holds while the front keeps filling the command queue.
// ----------------------------------------------------------------------------
module token_bucket_shaper_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        func,
    input  logic [15:0]                 packet_id,
    input  logic [7:0]                  packet_size,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        token_added,
    output logic                        token_dropped,
    output logic                        packet_released,
    output logic [15:0]                 released_id,
    output logic [7:0]                  released_size,
    output logic                        packet_refused,
    output logic [7:0]                  tokens_now,
    output logic [4:0]                  queue_count
);
    import tbs_pkg::*;

    logic [15:0] token_interval_reg;
    logic [7:0]  bucket_depth_reg;
    logic        cfg_write;
    reg_index_t  reg_index;
    cfg_t        cfg;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;
    result_t     result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = (paddr[2] == 1'b1) ? REG_BUCKET_DEPTH : REG_TOKEN_INTERVAL;

    always_comb
    begin
        case (reg_index)
            REG_TOKEN_INTERVAL: prdata = {16'd0, token_interval_reg};
            REG_BUCKET_DEPTH:   prdata = {24'd0, bucket_depth_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_interval_reg <= INTERVAL_RESET;
            bucket_depth_reg   <= DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_TOKEN_INTERVAL: token_interval_reg <= pwdata[15:0];
                REG_BUCKET_DEPTH:   bucket_depth_reg   <= pwdata[7:0];
                default:            token_interval_reg <= token_interval_reg;
            endcase
        end
    end

    assign cfg.token_interval = token_interval_reg;
    assign cfg.bucket_depth   = bucket_depth_reg;

    tbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .func        (func),
        .packet_id   (packet_id),
        .packet_size (packet_size),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    tbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign token_added     = result.token_added;
    assign token_dropped   = result.token_dropped;
    assign packet_released = result.packet_released;
    assign released_id     = result.released_id;
    assign released_size   = result.released_size;
    assign packet_refused  = result.packet_refused;
    assign tokens_now      = result.tokens_now;
    assign queue_count     = result.queue_count;

endmodule
